>>> sv/cxd_pkg.sv
// Shared types, constants and key table for the chained XOR decryptor.
`timescale 1ns / 1ps

package cxd_pkg;

   localparam int KEY_LENGTH = 10;
   localparam int KEY_IDX_W  = 4;
   localparam int LEN_W      = 16;
   localparam int CHECKS     = 4;
   localparam int CHECK_IDX_W = 2;

   localparam logic [LEN_W-1:0] PAYLOAD_LENGTH_RESET = 16'd2498;

   localparam logic [7:0] KEY_TABLE [KEY_LENGTH] = '{
      8'd15, 8'd50, 8'd89, 8'd240, 8'd147, 8'd34, 8'd86, 8'd9, 8'd32, 8'd208
   };

   // check byte order within the trailer
   localparam logic [CHECK_IDX_W-1:0] CHK_SUM     = 2'd0;
   localparam logic [CHECK_IDX_W-1:0] CHK_NEGSUM  = 2'd1;
   localparam logic [CHECK_IDX_W-1:0] CHK_PRODUCT = 2'd2;
   localparam logic [CHECK_IDX_W-1:0] CHK_XOR     = 2'd3;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       first;
   } cxd_req_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       is_verdict;
      logic       sum_ok;
      logic       negsum_ok;
      logic       product_ok;
      logic       xor_ok;
      logic       all_ok;
   } cxd_rsp_type;

   typedef struct packed {
      logic        has_result;
      cxd_rsp_type rsp;
   } cxd_step_out_type;

endpackage

>>> sv/cxd_step.sv
// Decode state and per-byte step logic: key chain, running checks, verdict.
`timescale 1ns / 1ps

module cxd_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  cxd_pkg::cxd_req_type         beat,
   input  logic [cxd_pkg::LEN_W-1:0]    payload_length,
   output cxd_pkg::cxd_step_out_type    step_out
);
   import cxd_pkg::*;

   logic [LEN_W-1:0]       position_ff,    position_in;
   logic [KEY_IDX_W-1:0]   key_index_ff,   key_index_in;
   logic [7:0]             prev_cipher_ff, prev_cipher_in;
   logic [7:0]             sum_ff,         sum_in;
   logic [7:0]             negsum_ff,      negsum_in;
   logic [7:0]             product_ff,     product_in;
   logic [7:0]             xor_ff,         xor_in;
   logic [CHECKS-1:0]      match_ff,       match_in;
   logic [CHECK_IDX_W-1:0] check_count_ff, check_count_in;
   logic                   done_ff,        done_in;

   always_comb begin
      logic [LEN_W-1:0]       pos;
      logic [KEY_IDX_W-1:0]   kidx;
      logic [KEY_IDX_W-1:0]   ki;
      logic [7:0]             prev, s, ns, pr, x, p, expect_byte;
      logic [15:0]            prod_full;
      logic [CHECKS-1:0]      flags;
      logic [CHECK_IDX_W-1:0] cnt;
      logic                   dn;

      // a start flag restarts the file before this byte is taken
      if (beat.first) begin
         pos   = '0;
         kidx  = KEY_IDX_W'(1);
         prev  = '0;
         s     = '0;
         ns    = '0;
         pr    = 8'd1;
         x     = '0;
         flags = '0;
         cnt   = '0;
         dn    = 1'b0;
      end else begin
         pos   = position_ff;
         kidx  = key_index_ff;
         prev  = prev_cipher_ff;
         s     = sum_ff;
         ns    = negsum_ff;
         pr    = product_ff;
         x     = xor_ff;
         flags = match_ff;
         cnt   = check_count_ff;
         dn    = done_ff;
      end

      ki        = (kidx < KEY_IDX_W'(KEY_LENGTH)) ? kidx : '0;
      p         = beat.cipher_byte ^ KEY_TABLE[ki] ^ prev;
      prod_full = pr * p;

      case (cnt)
         CHK_SUM:     expect_byte = s;
         CHK_NEGSUM:  expect_byte = ns;
         CHK_PRODUCT: expect_byte = pr;
         default:     expect_byte = x;
      endcase

      position_in    = pos;
      key_index_in   = kidx;
      prev_cipher_in = prev;
      sum_in         = s;
      negsum_in      = ns;
      product_in     = pr;
      xor_in         = x;
      match_in       = flags;
      check_count_in = cnt;
      done_in        = dn;
      step_out       = '0;

      if (dn) begin
         // trailing bytes after the verdict are dropped
      end else if (pos < payload_length) begin
         prev_cipher_in = beat.cipher_byte;
         key_index_in   = (ki == KEY_IDX_W'(KEY_LENGTH - 1)) ? '0 : ki + 1'b1;
         position_in    = pos + 1'b1;
         sum_in         = s + p;
         negsum_in      = ns - p;
         product_in     = prod_full[7:0] + 8'd1;
         xor_in         = x ^ p;
         step_out.has_result     = 1'b1;
         step_out.rsp.plain_byte = p;
      end else begin
         if (beat.cipher_byte == expect_byte)
            match_in = flags | (CHECKS'(1) << cnt);
         check_count_in = cnt + 1'b1;
         if (cnt == CHK_XOR) begin
            done_in = 1'b1;
            step_out.has_result     = 1'b1;
            step_out.rsp.is_verdict = 1'b1;
            step_out.rsp.sum_ok     = match_in[CHK_SUM];
            step_out.rsp.negsum_ok  = match_in[CHK_NEGSUM];
            step_out.rsp.product_ok = match_in[CHK_PRODUCT];
            step_out.rsp.xor_ok     = match_in[CHK_XOR];
            step_out.rsp.all_ok     = &match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         key_index_ff   <= KEY_IDX_W'(1);
         prev_cipher_ff <= '0;
         sum_ff         <= '0;
         negsum_ff      <= '0;
         product_ff     <= 8'd1;
         xor_ff         <= '0;
         match_ff       <= '0;
         check_count_ff <= '0;
         done_ff        <= 1'b0;
      end else if (advance) begin
         position_ff    <= position_in;
         key_index_ff   <= key_index_in;
         prev_cipher_ff <= prev_cipher_in;
         sum_ff         <= sum_in;
         negsum_ff      <= negsum_in;
         product_ff     <= product_in;
         xor_ff         <= xor_in;
         match_ff       <= match_in;
         check_count_ff <= check_count_in;
         done_ff        <= done_in;
      end
   end

endmodule

>>> sv/chained_xor_decrypt_with_checksums_core.sv
// Top level of the chained XOR decryptor with four running checks.
`timescale 1ns / 1ps

// Usage:
//  - req channel (valid/ready) carries one cipher byte per beat; first=1
//    marks the first byte of a file and restarts the decode state.
//  - Each of the first payload_length bytes yields one rsp beat with the
//    plain byte. The next four bytes are check bytes (sum, negated sum,
//    product-plus-one, xor); the first three yield nothing, the fourth yields
//    a verdict beat (is_verdict=1, plain_byte=0, per-check flags, all_ok).
//    Bytes after the verdict are swallowed until the next first=1.
//  - csr_we/csr_wdata write payload_length (reset 2498); write only idle.
//  - Datapath: an accepted byte goes through one input register, the step
//    logic and one output register before it shows on rsp.
//  - Throughput: one byte per cycle while rsp is not stalled; the critical
//    path is the 8x8 multiply of the product check plus its increment.
//  - Stall: the output register holds a result while rsp_ready is low; the
//    input register keeps taking bytes that produce no result, and bytes that
//    do wait in it, so req_ready drops only when both stages are full.
//  - Reset (synchronous) empties both stages and returns the decoder to the
//    start of a file, so a stream with no first flag decodes from scratch.
module chained_xor_decrypt_with_checksums_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  cxd_pkg::cxd_req_type       req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cxd_pkg::cxd_rsp_type       rsp_data,
   input  logic                       csr_we,
   input  logic [cxd_pkg::LEN_W-1:0]  csr_wdata
);
   import cxd_pkg::*;

   logic [LEN_W-1:0] payload_length_ff;

   // input stage
   logic        in_valid_ff;
   cxd_req_type in_beat_ff;

   // output stage
   logic        rsp_valid_ff;
   cxd_rsp_type rsp_data_ff;

   cxd_step_out_type step_out;
   logic             out_free;
   logic             out_load;
   logic             in_adv;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a byte with no result never waits on the output side
   assign in_adv    = in_valid_ff && (!step_out.has_result || out_free);
   assign out_load  = in_valid_ff && step_out.has_result && out_free;
   assign req_ready = !in_valid_ff || in_adv;

   always_ff @(posedge clock) begin
      if (reset)
         payload_length_ff <= PAYLOAD_LENGTH_RESET;
      else if (csr_we)
         payload_length_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid)
         in_beat_ff <= req_data;
   end

   cxd_step u_step (
      .clock          (clock),
      .reset          (reset),
      .advance        (in_adv),
      .beat           (in_beat_ff),
      .payload_length (payload_length_ff),
      .step_out       (step_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load)
         rsp_data_ff <= step_out.rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/cxd_checker.sv
// Port-level checks for the chained XOR decryptor, bound to the top level.
`timescale 1ns / 1ps

module cxd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input cxd_pkg::cxd_rsp_type       rsp_data
);
   import cxd_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_verdict_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_verdict |-> rsp_data.plain_byte == 8'd0)
      else $error("verdict beat carries a plain byte");

   a_payload_flags_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_verdict |->
         !rsp_data.sum_ok && !rsp_data.negsum_ok && !rsp_data.product_ok &&
         !rsp_data.xor_ok && !rsp_data.all_ok)
      else $error("payload beat carries check flags");

   a_all_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_verdict |->
         rsp_data.all_ok == (rsp_data.sum_ok && rsp_data.negsum_ok &&
                             rsp_data.product_ok && rsp_data.xor_ok))
      else $error("all_ok disagrees with the check flags");

endmodule

bind chained_xor_decrypt_with_checksums_core cxd_checker u_cxd_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for the chained XOR decryptor core.
`timescale 1ns / 1ps

module tb;
   import cxd_pkg::*;

   localparam int unsigned BEAT_TARGET  = 1150;
   localparam int unsigned SETTLE_TICKS = 8;       // pipeline is two stages deep
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned SHOW_LIMIT   = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   cxd_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   cxd_rsp_type           rsp_data;
   logic                  csr_we = 1'b0;
   logic [LEN_W-1:0]      csr_wdata = '0;

   chained_xor_decrypt_with_checksums_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------
   cxd_req_type      cipher_q[$];      // beats waiting to be offered on req
   cxd_rsp_type      due_q[$];         // decoded beats the core still owes us
   logic             steady = 1'b0;    // when set, neither side idles
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      file_beats = 0;

   // Decoder copy, advanced once per accepted req beat.
   logic [LEN_W-1:0]       cfg_len;
   logic [LEN_W-1:0]       dec_pos;
   logic [KEY_IDX_W-1:0]   dec_key;
   logic [7:0]             dec_prev;
   logic [7:0]             dec_sum;
   logic [7:0]             dec_neg;
   logic [7:0]             dec_prod;
   logic [7:0]             dec_xor;
   logic [CHECKS-1:0]      dec_flags;
   logic [CHECK_IDX_W-1:0] dec_checks;
   logic                   dec_done;

   // One byte of the chained cipher: key entry and previous cipher byte.
   function automatic logic [7:0] unmask_byte(input logic [7:0] c,
                                              input logic [KEY_IDX_W-1:0] ki,
                                              input logic [7:0] prev);
      return c ^ KEY_TABLE[ki] ^ prev;
   endfunction

   function automatic logic [KEY_IDX_W-1:0] next_key(input logic [KEY_IDX_W-1:0] ki);
      return (ki == KEY_IDX_W'(KEY_LENGTH - 1)) ? '0 : ki + 1'b1;
   endfunction

   task automatic restart_decoder();
      dec_pos    = '0;
      dec_key    = KEY_IDX_W'(1);
      dec_prev   = 8'd0;
      dec_sum    = 8'd0;
      dec_neg    = 8'd0;
      dec_prod   = 8'd1;
      dec_xor    = 8'd0;
      dec_flags  = '0;
      dec_checks = CHK_SUM;
      dec_done   = 1'b0;
   endtask

   // Work out what one cipher beat yields; at most one rsp beat per req beat.
   task automatic decode_step(input cxd_req_type beat);
      cxd_rsp_type          r;
      logic [7:0]           p;
      logic [7:0]           want;
      logic [KEY_IDX_W-1:0] ki;
      r = '0;
      if (beat.first)
         restart_decoder();
      if (dec_done) begin
         // trailing bytes after the verdict are swallowed
      end else if (dec_pos < cfg_len) begin
         ki = (dec_key < KEY_LENGTH) ? dec_key : '0;
         p  = unmask_byte(beat.cipher_byte, ki, dec_prev);
         dec_prev = beat.cipher_byte;
         dec_key  = next_key(ki);
         dec_pos  = dec_pos + 1'b1;
         dec_sum  = dec_sum + p;
         dec_neg  = dec_neg - p;
         dec_prod = dec_prod * p + 8'd1;
         dec_xor  = dec_xor ^ p;
         r.plain_byte = p;
         due_q.push_back(r);
      end else begin
         case (dec_checks)
            CHK_SUM:     want = dec_sum;
            CHK_NEGSUM:  want = dec_neg;
            CHK_PRODUCT: want = dec_prod;
            default:     want = dec_xor;
         endcase
         if (beat.cipher_byte == want)
            dec_flags[dec_checks] = 1'b1;
         if (dec_checks == CHK_XOR) begin
            // fourth check byte closes the file with the verdict beat
            dec_done     = 1'b1;
            r.is_verdict = 1'b1;
            r.sum_ok     = dec_flags[CHK_SUM];
            r.negsum_ok  = dec_flags[CHK_NEGSUM];
            r.product_ok = dec_flags[CHK_PRODUCT];
            r.xor_ok     = dec_flags[CHK_XOR];
            r.all_ok     = &dec_flags;
            due_q.push_back(r);
         end else begin
            dec_checks = dec_checks + 1'b1;
         end
      end
   endtask

   // Register copy follows the CSR port edge for edge.
   always @(posedge clock) begin
      if (reset)
         cfg_len <= PAYLOAD_LENGTH_RESET;
      else if (csr_we)
         cfg_len <= csr_wdata;
   end

   // ---------------------------------------------------------------------
   // Driver: offers queued cipher beats, idles at random between them.
   // A beat accepted at this edge is decoded here, so the expectation is
   // queued before the core can possibly return it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         restart_decoder();
      end else begin
         if (req_valid && req_ready)
            decode_step(req_data);
         if (!req_valid || req_ready) begin
            if (cipher_q.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
               req_valid <= 1'b1;
               req_data  <= cipher_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random backpressure, every rsp beat checked against the
   // oldest outstanding expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cxd_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               if (error_count < SHOW_LIMIT)
                  $display("unexpected rsp beat: plain=%02h verdict=%b flags=%b%b%b%b all=%b",
                           rsp_data.plain_byte, rsp_data.is_verdict, rsp_data.sum_ok,
                           rsp_data.negsum_ok, rsp_data.product_ok, rsp_data.xor_ok,
                           rsp_data.all_ok);
               error_count++;
            end else begin
               want = due_q.pop_front();
               if (rsp_data.plain_byte !== want.plain_byte ||
                   rsp_data.is_verdict !== want.is_verdict ||
                   rsp_data.sum_ok     !== want.sum_ok     ||
                   rsp_data.negsum_ok  !== want.negsum_ok  ||
                   rsp_data.product_ok !== want.product_ok ||
                   rsp_data.xor_ok     !== want.xor_ok     ||
                   rsp_data.all_ok     !== want.all_ok) begin
                  if (error_count < SHOW_LIMIT) begin
                     $write("rsp mismatch: expected plain=%02h verdict=%b flags=%b%b%b%b all=%b",
                            want.plain_byte, want.is_verdict, want.sum_ok,
                            want.negsum_ok, want.product_ok, want.xor_ok, want.all_ok);
                     $display(", got plain=%02h verdict=%b flags=%b%b%b%b all=%b",
                              rsp_data.plain_byte, rsp_data.is_verdict, rsp_data.sum_ok,
                              rsp_data.negsum_ok, rsp_data.product_ok, rsp_data.xor_ok,
                              rsp_data.all_ok);
                  end
                  error_count++;
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 33);
      end
   end

   // Watchdog: a hung core ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("chained_xor_decrypt_with_checksums_core regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers (run at the falling edge, away from the clocked blocks)
   // ---------------------------------------------------------------------
   task automatic push_beat(input logic [7:0] c, input logic first);
      cxd_req_type b;
      b.cipher_byte = c;
      b.first       = first;
      cipher_q.push_back(b);
   endtask

   // Sender holds off until every owed beat is back, then lets any
   // result-less check byte still in the pipe drain out.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (cipher_q.size() != 0 || req_valid || due_q.size() != 0);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_len(input logic [LEN_W-1:0] len);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // Correct trailer for whatever the decoder has seen so far.
   task automatic push_trailer_now();
      push_beat(dec_sum, 1'b0);
      push_beat(dec_neg, 1'b0);
      push_beat(dec_prod, 1'b0);
      push_beat(dec_xor, 1'b0);
   endtask

   // One file: len payload beats plus four check beats. A sound file is sent
   // whole; otherwise it is cut short somewhere before the verdict.
   task automatic push_file(input int unsigned len, input bit sound);
      logic [7:0]           c;
      logic [7:0]           p;
      logic [7:0]           prev;
      logic [7:0]           s;
      logic [7:0]           n;
      logic [7:0]           pr;
      logic [7:0]           x;
      logic [7:0]           chk[CHECKS];
      logic [KEY_IDX_W-1:0] ki;
      int unsigned          stop;
      prev = 8'd0;
      ki   = KEY_IDX_W'(1);
      s    = 8'd0;
      n    = 8'd0;
      pr   = 8'd1;
      x    = 8'd0;
      stop = sound ? len + CHECKS : $urandom_range(len + CHECKS - 1, 1);
      for (int i = 0; i < len; i++) begin
         c    = 8'($urandom);
         p    = unmask_byte(c, ki, prev);
         prev = c;
         ki   = next_key(ki);
         s    = s + p;
         n    = n - p;
         pr   = pr * p + 8'd1;
         x    = x ^ p;
         if (i < stop)
            push_beat(c, i == 0);
      end
      chk[CHK_SUM]     = s;
      chk[CHK_NEGSUM]  = n;
      chk[CHK_PRODUCT] = pr;
      chk[CHK_XOR]     = x;
      for (int j = 0; j < CHECKS; j++) begin
         // about one check byte in four is damaged so both verdicts show up
         if ($urandom_range(3) == 0)
            chk[j] = 8'($urandom);
         if (len + j < stop)
            push_beat(chk[j], 1'b0);
      end
      file_beats += stop;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned phase;
      int unsigned len;
      int unsigned files;
      int unsigned roll;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // No start flag after reset: decode runs under the reset length.
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'h80, 1'b0);
      push_beat(8'h7F, 1'b0);
      wait_drained();
      // Length dropped to the current position: next beats are check bytes.
      write_len(LEN_W'(4));
      push_trailer_now();

      // Zero length: checks compare against start values at once.
      wait_drained();
      write_len('0);
      push_beat(8'h00, 1'b1);
      push_beat(8'h00, 1'b0);
      push_beat(8'h01, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);   // after the verdict, swallowed
      push_beat(8'hFF, 1'b1);   // every check wrong
      push_beat(8'hFE, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h01, 1'b0);

      // Longest length, then lowered below the position mid-file.
      wait_drained();
      write_len('1);
      push_beat(8'hA5, 1'b1);
      push_beat(8'h5A, 1'b0);
      push_beat(8'hC3, 1'b0);
      wait_drained();
      write_len(LEN_W'(2));
      push_trailer_now();

      // Random phases: mostly short files, sound ones dominate so the check
      // phase is reached often; cut files and loose noise mixed in.
      phase = 0;
      while (file_beats < BEAT_TARGET) begin
         roll = $urandom_range(15);
         if (roll == 0)
            len = 1;
         else if (roll == 1)
            len = $urandom_range(64, 17);
         else
            len = $urandom_range(16, 2);
         wait_drained();
         write_len(LEN_W'(len));
         steady = (phase == 3);   // one long stretch with no idling on either side
         files  = steady ? 12 : $urandom_range(8, 3);
         repeat (files) begin
            roll = $urandom_range(9);
            if (roll < 7) begin
               push_file(len, 1'b1);
               repeat ($urandom_range(2)) push_beat(8'($urandom), 1'b0);
            end else if (roll < 9) begin
               push_file(len, 1'b0);
            end else begin
               repeat ($urandom_range(6, 1)) push_beat(8'($urandom), $urandom_range(3) == 0);
            end
         end
         phase++;
      end

      wait_drained();
      steady = 1'b0;
      if (error_count == 0 && due_q.size() == 0)
         $display("chained_xor_decrypt_with_checksums_core regression: pass");
      else
         $display("chained_xor_decrypt_with_checksums_core regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
sv/cxd_pkg.sv
sv/cxd_step.sv
sv/chained_xor_decrypt_with_checksums_core.sv
sv/cxd_checker.sv
sim/tb.sv
